// File: sv/pbpm_pkg.sv
// shared types and codes for the page buffer pool manager
`default_nettype none
package pbpm_pkg;
    localparam int CacheSlotsDefault = 16;
    localparam int PageIdBitsDefault = 48;

    localparam logic [2:0] OP_GET     = 3'd0;
    localparam logic [2:0] OP_RELEASE = 3'd1;
    localparam logic [2:0] OP_DIRTY   = 3'd2;
    localparam logic [2:0] OP_FREE    = 3'd3;
    localparam logic [2:0] OP_NEW     = 3'd4;
    localparam logic [2:0] OP_FLUSH   = 3'd5;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_LOADED    = 3'd1;
    localparam logic [2:0] ST_NULL      = 3'd2;
    localparam logic [2:0] ST_NO_SLOT   = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;
    localparam logic [2:0] ST_UNDERFLOW = 3'd5;

    localparam logic [2:0] CMD_NONE      = 3'd0;
    localparam logic [2:0] CMD_READ      = 3'd1;
    localparam logic [2:0] CMD_EVICT     = 3'd2;
    localparam logic [2:0] CMD_WRITEBACK = 3'd3;
    localparam logic [2:0] CMD_FREE      = 3'd4;
    localparam logic [2:0] CMD_WRITE_NEW = 3'd5;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  slot;
        logic [2:0]  command;
        logic [47:0] target_page;
        logic [47:0] victim_page;
        logic        last;
    } result_t;
endpackage
`default_nettype wire

// File: sv/page_buffer_pool_manager.sv
// page buffer pool manager: slot table with a one-slot-per-cycle scan sequencer
// get, release, mark dirty, free and new page: the scan visits one active slot per cycle, then
// the decide state registers the first result beat; null id and unknown op answer in the
// cycle after the request beat; flush emits each write back at its slot
// throughput: one item at a time; a new page over a dirty victim adds a write back beat;
// result stalls hold the sequencer; reset: synchronous
// active-low aresetn clears slot state, stamps, counter, high water mark; active_slots is 16
`default_nettype none
module page_buffer_pool_manager (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [4:0]  cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_op,
    input  wire logic [47:0] s_page_id,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_status,
    output logic [3:0]       m_slot,
    output logic [2:0]       m_command,
    output logic [47:0]      m_target_page,
    output logic [47:0]      m_victim_page,
    output logic             m_last
);
    import pbpm_pkg::*;

    localparam int CACHE_SLOTS = CacheSlotsDefault;
    localparam int IW = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
    localparam int CW = $clog2(CACHE_SLOTS + 1);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_DONE  = 3'd2;
    localparam logic [2:0] S_OUT   = 3'd3;
    localparam logic [2:0] S_OUT2  = 3'd4;
    localparam logic [2:0] S_FLUSH = 3'd5;

    // slot table, one register per slot
    logic [47:0] page_reg  [CACHE_SLOTS];
    logic [15:0] pins_reg  [CACHE_SLOTS];
    logic        dirty_reg [CACHE_SLOTS];
    logic [31:0] stamp_reg [CACHE_SLOTS];
    logic [31:0] counter_reg;
    logic [CW-1:0] hw_reg;
    logic [4:0]  active_reg;

    logic [2:0]  state_reg;
    logic [2:0]  op_reg;
    logic [47:0] pid_reg;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] act_reg;
    logic [CW-1:0] lim_reg;
    // scan results
    logic        hit_v_reg, emp_v_reg, c_v_reg, u_v_reg, hi_v_reg;
    logic [IW-1:0] hit_reg, emp_reg, c_reg, u_reg, hi_reg;
    logic [31:0] cage_reg, uage_reg;
    logic        any_flush_reg;

    result_t out_reg, out2_reg;
    logic    outv_reg;

    // effective active slot count
    logic [CW-1:0] act_eff;
    always_comb begin
        if (active_reg == 5'd0) act_eff = CW'(1);
        else if (32'(active_reg) > CACHE_SLOTS) act_eff = CW'(CACHE_SLOTS);
        else act_eff = CW'(active_reg);
    end

    logic [IW-1:0] ix;
    logic [31:0]   age;
    assign ix  = idx_reg[IW-1:0];
    // the shared compare unit looks at one slot per cycle
    assign age = counter_reg - stamp_reg[ix];

    logic [47:0] pid_in;
    assign pid_in = s_page_id;

    assign s_ready = (state_reg == S_IDLE) && !outv_reg;
    assign m_valid = outv_reg;
    assign m_status = out_reg.status;
    assign m_slot = out_reg.slot;
    assign m_command = out_reg.command;
    assign m_target_page = out_reg.target_page;
    assign m_victim_page = out_reg.victim_page;
    assign m_last = out_reg.last;

    function automatic result_t mk(logic [2:0] st, logic [3:0] sl, logic [2:0] cm,
                                   logic [47:0] tp, logic [47:0] vp, logic l);
        result_t r;
        r.status = st; r.slot = sl; r.command = cm;
        r.target_page = tp; r.victim_page = vp; r.last = l;
        return r;
    endfunction

    logic [3:0] ix4, hit4, emp4, c4, u4, hi4;
    assign ix4  = 4'(ix);
    assign hit4 = 4'(hit_reg);
    assign emp4 = 4'(emp_reg);
    assign c4   = 4'(c_reg);
    assign u4   = 4'(u_reg);
    assign hi4  = 4'(hi_reg);

    logic scan_end;
    assign scan_end = (idx_reg + CW'(1) >= act_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            outv_reg    <= 1'b0;
            counter_reg <= '0;
            hw_reg      <= '0;
            active_reg  <= 5'd16;
            for (int i = 0; i < CACHE_SLOTS; i++) begin
                page_reg[i]  <= '0;
                pins_reg[i]  <= '0;
                dirty_reg[i] <= 1'b0;
                stamp_reg[i] <= '0;
            end
        end else begin
            if (cfg_we) active_reg <= cfg_wdata;
            if (outv_reg && m_ready) outv_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid && s_ready) begin
                        op_reg    <= s_op;
                        pid_reg   <= pid_in;
                        idx_reg   <= '0;
                        act_reg   <= act_eff;
                        lim_reg   <= (hw_reg < act_eff) ? hw_reg : act_eff;
                        hit_v_reg <= 1'b0; emp_v_reg <= 1'b0;
                        c_v_reg   <= 1'b0; u_v_reg <= 1'b0; hi_v_reg <= 1'b0;
                        cage_reg  <= '0; uage_reg <= '0;
                        any_flush_reg <= 1'b0;
                        if (s_op <= OP_NEW && pid_in == 48'd0) begin
                            out_reg  <= mk(ST_NULL, 4'd0, CMD_NONE, '0, '0, 1'b1);
                            outv_reg <= 1'b1;
                        end else if (s_op > OP_FLUSH) begin
                            out_reg  <= mk(ST_OK, 4'd0, CMD_NONE, '0, '0, 1'b1);
                            outv_reg <= 1'b1;
                        end else if (s_op == OP_FLUSH) begin
                            state_reg <= S_FLUSH;
                        end else begin
                            if (s_op == OP_GET) counter_reg <= counter_reg + 32'd1;
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    // one slot per cycle: match, empty, lru and top unpinned
                    if (!hit_v_reg && page_reg[ix] == pid_reg &&
                        (op_reg != OP_GET || idx_reg < lim_reg)) begin
                        hit_v_reg <= 1'b1; hit_reg <= ix;
                    end
                    if (!emp_v_reg && page_reg[ix] == 48'd0) begin
                        emp_v_reg <= 1'b1; emp_reg <= ix;
                    end
                    if (pins_reg[ix] == 16'd0) begin
                        hi_v_reg <= 1'b1; hi_reg <= ix;
                    end
                    // lru candidates only before the first empty slot
                    if (!emp_v_reg && page_reg[ix] != 48'd0 && pins_reg[ix] == 16'd0) begin
                        if (!dirty_reg[ix] && age > cage_reg) begin
                            c_v_reg <= 1'b1; c_reg <= ix; cage_reg <= age;
                        end
                        if (age > uage_reg) begin
                            u_v_reg <= 1'b1; u_reg <= ix; uage_reg <= age;
                        end
                    end
                    idx_reg <= idx_reg + CW'(1);
                    if (scan_end) state_reg <= S_DONE;
                end
                S_DONE: begin
                    state_reg <= S_OUT;
                    outv_reg  <= 1'b1;
                    case (op_reg)
                        OP_GET: begin
                            if (hit_v_reg) begin
                                if (pins_reg[hit_reg] != 16'hFFFF)
                                    pins_reg[hit_reg] <= pins_reg[hit_reg] + 16'd1;
                                stamp_reg[hit_reg] <= counter_reg;
                                out_reg <= mk(ST_OK, hit4, CMD_NONE, '0, '0, 1'b1);
                            end else if (emp_v_reg || c_v_reg || u_v_reg) begin
                                logic [IW-1:0] s;
                                s = emp_v_reg ? emp_reg : (c_v_reg ? c_reg : u_reg);
                                page_reg[s]  <= pid_reg;
                                pins_reg[s]  <= 16'd1;
                                dirty_reg[s] <= 1'b0;
                                stamp_reg[s] <= counter_reg;
                                if (emp_v_reg) begin
                                    if (hw_reg < CW'(s) + CW'(1)) hw_reg <= CW'(s) + CW'(1);
                                    out_reg <= mk(ST_LOADED, emp4, CMD_READ, pid_reg, '0, 1'b1);
                                end else if (c_v_reg)
                                    out_reg <= mk(ST_LOADED, c4, CMD_READ, pid_reg, '0, 1'b1);
                                else
                                    out_reg <= mk(ST_LOADED, u4, CMD_EVICT, pid_reg,
                                                  page_reg[u_reg], 1'b1);
                            end else begin
                                out_reg <= mk(ST_NO_SLOT, 4'd0, CMD_NONE, '0, '0, 1'b1);
                            end
                        end
                        OP_RELEASE: begin
                            if (!hit_v_reg)
                                out_reg <= mk(ST_NOT_FOUND, 4'd0, CMD_NONE, '0, '0, 1'b1);
                            else if (pins_reg[hit_reg] == 16'd0)
                                out_reg <= mk(ST_UNDERFLOW, hit4, CMD_NONE, '0, '0, 1'b1);
                            else begin
                                pins_reg[hit_reg] <= pins_reg[hit_reg] - 16'd1;
                                out_reg <= mk(ST_OK, hit4, CMD_NONE, '0, '0, 1'b1);
                            end
                        end
                        OP_DIRTY: begin
                            if (!hit_v_reg)
                                out_reg <= mk(ST_NOT_FOUND, 4'd0, CMD_NONE, '0, '0, 1'b1);
                            else begin
                                dirty_reg[hit_reg] <= 1'b1;
                                out_reg <= mk(ST_OK, hit4, CMD_NONE, '0, '0, 1'b1);
                            end
                        end
                        OP_FREE: begin
                            if (!hit_v_reg)
                                out_reg <= mk(ST_NOT_FOUND, 4'd0, CMD_NONE, '0, '0, 1'b1);
                            else begin
                                page_reg[hit_reg]  <= '0;
                                pins_reg[hit_reg]  <= '0;
                                dirty_reg[hit_reg] <= 1'b0;
                                out_reg <= mk(ST_OK, hit4, CMD_FREE, pid_reg, '0, 1'b1);
                            end
                        end
                        default: begin
                            // new page
                            if (emp_v_reg || hi_v_reg) begin
                                logic [IW-1:0] s;
                                logic [3:0]    s4;
                                s  = emp_v_reg ? emp_reg : hi_reg;
                                s4 = emp_v_reg ? emp4 : hi4;
                                page_reg[s]  <= pid_reg;
                                pins_reg[s]  <= '0;
                                dirty_reg[s] <= 1'b0;
                                if (hw_reg < CW'(s) + CW'(1)) hw_reg <= CW'(s) + CW'(1);
                                if (!emp_v_reg && dirty_reg[s]) begin
                                    out_reg  <= mk(ST_OK, s4, CMD_WRITEBACK, '0,
                                                   page_reg[s], 1'b0);
                                    out2_reg <= mk(ST_OK, s4, CMD_WRITE_NEW, pid_reg,
                                                   '0, 1'b1);
                                    state_reg <= S_OUT2;
                                end else begin
                                    out_reg <= mk(ST_OK, s4, CMD_WRITE_NEW, pid_reg, '0, 1'b1);
                                end
                            end else begin
                                out_reg <= mk(ST_NO_SLOT, 4'd0, CMD_NONE, '0, '0, 1'b1);
                            end
                        end
                    endcase
                end
                S_OUT: begin
                    if (!outv_reg || m_ready) state_reg <= S_IDLE;
                end
                S_OUT2: begin
                    if (outv_reg && m_ready) begin
                        out_reg   <= out2_reg;
                        outv_reg  <= 1'b1;
                        state_reg <= S_OUT;
                    end
                end
                S_FLUSH: begin
                    // one slot per cycle, stall while the output beat waits
                    if (!outv_reg || m_ready) begin
                        if (idx_reg >= act_reg) begin
                            state_reg <= S_IDLE;
                            if (!any_flush_reg) begin
                                out_reg  <= mk(ST_OK, 4'd0, CMD_NONE, '0, '0, 1'b1);
                                outv_reg <= 1'b1;
                            end
                        end else begin
                            idx_reg <= idx_reg + CW'(1);
                            if (dirty_reg[ix]) begin
                                logic more;
                                more = 1'b0;
                                for (int j = 0; j < CACHE_SLOTS; j++)
                                    if (CW'(j) > idx_reg && CW'(j) < act_reg && dirty_reg[j])
                                        more = 1'b1;
                                dirty_reg[ix] <= 1'b0;
                                any_flush_reg <= 1'b1;
                                out_reg  <= mk(ST_OK, ix4, CMD_WRITEBACK, '0, page_reg[ix],
                                               !more);
                                outv_reg <= 1'b1;
                                if (!more) state_reg <= S_IDLE;
                            end
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (state_reg == S_IDLE)) else $error("ready outside idle");
    a_hw_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(hw_reg) <= CACHE_SLOTS) else $error("high water past slot count");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready) else $error("back to back accept");
`endif
endmodule
`default_nettype wire
